### rtl/crcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the crc-8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam int DEFAULT_MAX_FRAME_LEN = 16;

    localparam logic [7:0] START_BYTE   = 8'h53;
    localparam logic [7:0] END_BYTE     = 8'h45;
    localparam logic [7:0] CRC_INIT     = 8'hFF;
    localparam logic [7:0] CRC_POLY     = 8'hD5;
    localparam logic [7:0] MIN_FRAME_LEN = 8'd7;
    localparam logic [15:0] POSITION_INDEX = 16'h6064;

    // byte positions within a frame
    localparam logic [4:0] POS_NODE     = 5'd2;
    localparam logic [4:0] POS_COMMAND  = 5'd3;
    localparam logic [4:0] POS_INDEX_LO = 5'd4;
    localparam logic [4:0] POS_INDEX_HI = 5'd5;
    localparam logic [4:0] POS_SUBINDEX = 5'd6;
    localparam logic [4:0] POS_DATA0    = 5'd7;
    localparam logic [4:0] POS_DATA3    = 5'd10;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CRC_ERROR = 2'd1,
        STATUS_BAD_END   = 2'd2,
        STATUS_BAD_LEN   = 2'd3
    } status_t;

    typedef struct packed {
        logic        is_position;
        logic [3:0]  data_count;
        logic [31:0] data_value;
        logic [7:0]  object_subindex;
        logic [15:0] object_index;
        logic [7:0]  command_code;
        logic [7:0]  node_id;
        logic [7:0]  frame_length;
        status_t     status;
    } result_t;

    // reflected crc-8, one byte per call
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/crcfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame state machine: start hunt, length check, field capture, crc and end
// check. Produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module crcfr_parser
    import crcfr_pkg::*;
#(
    parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_END
    } phase_t;

    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_LEN);

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_reg, length_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  rx_crc_reg, rx_crc_next;
    logic [7:0]  node_reg, node_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] index_reg, index_next;
    logic [7:0]  subindex_reg, subindex_next;
    logic [31:0] data_reg, data_next;

    logic [1:0]  data_lane;
    logic [7:0]  count_raw;

    assign data_lane = 2'(pos_reg - POS_DATA0);
    assign count_raw = length_reg - MIN_FRAME_LEN;

    always_comb begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        rx_crc_next   = rx_crc_reg;
        node_next     = node_reg;
        command_next  = command_reg;
        index_next    = index_reg;
        subindex_next = subindex_reg;
        data_next     = data_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (byte_valid) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (byte_data == START_BYTE) begin
                        length_next   = '0;
                        pos_next      = '0;
                        crc_next      = CRC_INIT;
                        rx_crc_next   = '0;
                        node_next     = '0;
                        command_next  = '0;
                        index_next    = '0;
                        subindex_next = '0;
                        data_next     = '0;
                        phase_next    = PH_LEN;
                    end
                end
                PH_LEN: begin
                    length_next = byte_data;
                    if (byte_data < MIN_FRAME_LEN || byte_data > MAX_LEN) begin
                        res_valid        = 1'b1;
                        res.status       = STATUS_BAD_LEN;
                        res.frame_length = byte_data;
                        phase_next       = PH_HUNT;
                    end else begin
                        crc_next   = crc8_step(CRC_INIT, byte_data);
                        pos_next   = POS_NODE;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if ({3'b000, pos_reg} >= length_reg) begin
                        rx_crc_next = byte_data;
                        phase_next  = PH_END;
                    end else begin
                        crc_next = crc8_step(crc_reg, byte_data);
                        case (pos_reg)
                            POS_NODE:     node_next           = byte_data;
                            POS_COMMAND:  command_next        = byte_data;
                            POS_INDEX_LO: index_next[7:0]     = byte_data;
                            POS_INDEX_HI: index_next[15:8]    = byte_data;
                            POS_SUBINDEX: subindex_next       = byte_data;
                            default: begin
                                if (pos_reg >= POS_DATA0 && pos_reg <= POS_DATA3) begin
                                    data_next[8*data_lane +: 8] = byte_data;
                                end
                            end
                        endcase
                        pos_next = pos_reg + 5'd1;
                    end
                end
                PH_END: begin
                    res_valid = 1'b1;
                    if (crc_reg != rx_crc_reg) begin
                        res.status = STATUS_CRC_ERROR;
                    end else if (byte_data != END_BYTE) begin
                        res.status = STATUS_BAD_END;
                    end else begin
                        res.status = STATUS_OK;
                    end
                    res.frame_length    = length_reg;
                    res.node_id         = node_reg;
                    res.command_code    = command_reg;
                    res.object_index    = index_reg;
                    res.object_subindex = subindex_reg;
                    res.data_value      = data_reg;
                    res.data_count      = (count_raw > 8'd15) ? 4'hF : count_raw[3:0];
                    res.is_position     = (index_reg == POSITION_INDEX);
                    phase_next          = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            length_reg   <= '0;
            pos_reg      <= '0;
            crc_reg      <= CRC_INIT;
            rx_crc_reg   <= '0;
            node_reg     <= '0;
            command_reg  <= '0;
            index_reg    <= '0;
            subindex_reg <= '0;
            data_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            rx_crc_reg   <= rx_crc_next;
            node_reg     <= node_next;
            command_reg  <= command_next;
            index_reg    <= index_next;
            subindex_reg <= subindex_next;
            data_reg     <= data_next;
        end
    end

endmodule

### rtl/crcfr_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_out_stage
// Result register with its handshake; it also gates input acceptance.
// ----------------------------------------------------------------------------
module crcfr_out_stage
    import crcfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    in_ready,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;

    // a byte may enter whenever the result slot is free or draining this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            data_reg <= res;
        end
    end

endmodule

### rtl/crc8_checked_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_checked_frame_receiver_core
// Receives serial bytes, deframes start/length/body/crc/end frames and
// reports one checked result per frame or per bad length byte.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  s_        in    tdata[7:0] rx_byte
//  m_        out   tuser[1:0] status; tdata frame fields (see port list)
//
//  one byte per cycle while s_tready is high; the crc update is a combinational unrolled step
//  a result appears in the output register the cycle after its last byte
//  synchronous active-low reset returns the parser to start hunting
//  input stalls only while a result waits and m_tready is low
// ----------------------------------------------------------------------------
module crc8_checked_frame_receiver_core
    import crcfr_pkg::*;
#(
    parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // frame_length, node_id, command_code, object_index,
                                   // object_subindex, data_value, data_count,
                                   // is_position, zero pad
    output logic [1:0]  m_tuser    // status
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign accept = s_tvalid && s_tready;

    crcfr_parser #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(accept),
        .byte_data (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    crcfr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_valid(res_valid),
        .res      (res),
        .in_ready (s_tready),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_data (out_data)
    );

    assign m_tuser = out_data.status;
    assign m_tdata = {3'b000,
                      out_data.is_position,
                      out_data.data_count,
                      out_data.data_value,
                      out_data.object_subindex,
                      out_data.object_index,
                      out_data.command_code,
                      out_data.node_id,
                      out_data.frame_length};

endmodule
